/* hw/rtl/lhl_pkg.sv */
// Shared types and constants for the LRU history list.
package lhl_pkg;

    localparam int MaxEntries = 16;
    localparam int IdxW       = $clog2(MaxEntries);
    localparam int CntW       = $clog2(MaxEntries + 1);

    localparam int KeyW   = 32;
    localparam int IdW    = 10;
    localparam int StampW = 32;
    localparam int AccW   = 16;
    localparam int OccW   = 5;
    localparam int CapW   = 5;

    localparam int EntryW   = KeyW + IdW + StampW + AccW;
    localparam int InDataW  = ((EntryW + 7) / 8) * 8;
    localparam int OutDataW = ((EntryW + OccW + 7) / 8) * 8;

    localparam logic [CapW-1:0] CapReset = CapW'(10);

    localparam logic ActInsert = 1'b0;
    localparam logic ActClear  = 1'b1;

    typedef struct packed {
        logic [AccW-1:0]   acc;
        logic [StampW-1:0] stamp;
        logic [IdW-1:0]    id;
        logic [KeyW-1:0]   key;
    } entry_t;

endpackage

/* hw/rtl/lhl_ram.sv */
// Generic simple dual-port RAM with registered read.
module lhl_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(Depth)-1:0] waddr,
    input  logic [Width-1:0]         wdata,
    input  logic [$clog2(Depth)-1:0] raddr,
    output logic [Width-1:0]         rdata
);

    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* hw/rtl/lru_history_list.sv */
// Top level of the LRU history list: move-to-front walk over an entry RAM.
// Each accepted item walks the entry RAM through its single read port, one stored entry per
// cycle; a clear or an insert into an empty list skips the walk. No new item is accepted
// until the previous result is loaded into the output register; a held result stalls the next.
// Reset: list empty, capacity 10; entry RAM contents are not cleared.
module lru_history_list import lhl_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CapW-1:0]     cfg_data,     // capacity
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [InDataW-1:0]  s_tdata,      // page_key, page_id, access_time, access_count
    input  logic [0:0]          s_tuser,      // action
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [OutDataW-1:0] m_tdata,      // evicted_key, evicted_id, evicted_time,
                                              // evicted_count, occupancy
    output logic [1:0]          m_tuser       // hit, evicted
);

    typedef enum logic [1:0] {ST_IDLE, ST_WALK, ST_DONE} state_t;

    state_t                state_reg;
    logic [CapW-1:0]       cap_reg;
    logic [CntW-1:0]       total_reg;
    logic [IdxW-1:0]       idx_reg;
    logic                  hit_reg;
    logic                  clr_reg;
    logic [KeyW-1:0]       key_reg;
    entry_t                carry_reg;
    entry_t                last_reg;
    logic                  m_valid_reg;
    logic [OutDataW-1:0]   m_data_reg;
    logic [1:0]            m_user_reg;

    entry_t                rd_entry;
    entry_t                in_entry;
    entry_t                ev_entry;
    logic                  ram_we;
    logic [IdxW-1:0]       ram_waddr;
    logic [IdxW-1:0]       ram_raddr;
    logic                  match;
    logic                  at_end;
    logic                  out_free;
    logic                  out_load;
    logic                  s_fire;
    logic                  ev;
    logic [CntW:0]         n_val;
    logic [CntW:0]         n_final;
    logic [CntW:0]         cap_eff;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == ST_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign in_entry  = entry_t'(s_tdata[EntryW-1:0]);
    assign out_free  = !m_valid_reg || m_tready;
    assign out_load  = (state_reg == ST_DONE) && out_free;

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

    assign match  = (rd_entry.key == key_reg);
    assign at_end = ((CntW'(idx_reg) + CntW'(1)) == total_reg);

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = (CntW+1)'(1);
        end
        else if (int'(cap_reg) > MaxEntries)
        begin
            cap_eff = (CntW+1)'(MaxEntries);
        end
        else
        begin
            cap_eff = (CntW+1)'(cap_reg);
        end
    end

    assign n_val    = hit_reg ? {1'b0, total_reg} : ({1'b0, total_reg} + (CntW+1)'(1));
    assign ev       = (n_val > cap_eff);
    assign n_final  = ev ? (n_val - (CntW+1)'(1)) : n_val;
    assign ev_entry = hit_reg ? last_reg : carry_reg;

    assign ram_we    = ((state_reg == ST_WALK) && !hit_reg)
                    || ((state_reg == ST_DONE) && !clr_reg && !hit_reg && !ev);
    assign ram_waddr = (state_reg == ST_WALK) ? idx_reg : total_reg[IdxW-1:0];
    assign ram_raddr = (state_reg == ST_WALK) ? (idx_reg + IdxW'(1)) : '0;

    lhl_ram #(
        .Width (EntryW),
        .Depth (MaxEntries)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (carry_reg),
        .raddr (ram_raddr),
        .rdata (rd_entry)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cap_reg     <= CapReset;
            total_reg   <= '0;
            idx_reg     <= '0;
            hit_reg     <= 1'b0;
            clr_reg     <= 1'b0;
            key_reg     <= '0;
            carry_reg   <= '0;
            last_reg    <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                cap_reg <= cfg_data;
            end

            if (out_load)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_valid_reg && m_tready)
            begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_fire)
                    begin
                        clr_reg   <= (s_tuser[0] == ActClear);
                        key_reg   <= in_entry.key;
                        carry_reg <= in_entry;
                        hit_reg   <= 1'b0;
                        idx_reg   <= '0;
                        if ((s_tuser[0] == ActClear) || (total_reg == '0))
                        begin
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_WALK:
                begin
                    // shift toward the back until the first key match, then pass through
                    if (!hit_reg)
                    begin
                        if (match)
                        begin
                            hit_reg  <= 1'b1;
                            last_reg <= carry_reg;
                        end
                        else
                        begin
                            carry_reg <= rd_entry;
                        end
                    end
                    else
                    begin
                        last_reg <= rd_entry;
                    end
                    if (at_end)
                    begin
                        state_reg <= ST_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + IdxW'(1);
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg   <= ST_IDLE;
                        if (clr_reg)
                        begin
                            m_data_reg <= '0;
                            m_user_reg <= '0;
                            total_reg  <= '0;
                        end
                        else
                        begin
                            m_user_reg <= {ev, hit_reg};
                            m_data_reg <= OutDataW'({OccW'(n_final), ev ? ev_entry : '0});
                            total_reg  <= n_final[CntW-1:0];
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* hw/rtl/lhl_checker.sv */
// Port-level checks for the LRU history list, bound to the top level.
module lhl_checker import lhl_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                cfg_valid,
    input logic                cfg_ready,
    input logic [CapW-1:0]     cfg_data,
    input logic                s_tvalid,
    input logic                s_tready,
    input logic [InDataW-1:0]  s_tdata,
    input logic [0:0]          s_tuser,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [OutDataW-1:0] m_tdata,
    input logic [1:0]          m_tuser
);

    logic [OccW-1:0] occ;

    assign occ = m_tdata[EntryW +: OccW];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    a_no_evict_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[1] |-> (m_tdata[EntryW-1:0] == '0))
        else $error("evicted fields not zero without eviction");

    a_occ_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != 2'b00) |-> (occ != '0))
        else $error("empty list after hit or eviction");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("item accepted back to back");

endmodule

bind lru_history_list lhl_checker u_lhl_checker (.*);

/* dv/tb_lru_history_list.sv */
// Testbench for the LRU history list: directed and random inserts and clears checked per item.
module tb_lru_history_list;
    import lhl_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic            hit;
        logic            evicted;
        entry_t          victim;
        logic [OccW-1:0] occ;
    } access_result_t;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [CapW-1:0]     cfg_data  = '0;
    logic                s_tvalid  = 1'b0;
    logic                s_tready;
    logic [InDataW-1:0]  s_tdata   = '0;
    logic [0:0]          s_tuser   = '0;
    logic                m_tvalid;
    logic                m_tready  = 1'b0;
    logic [OutDataW-1:0] m_tdata;
    logic [1:0]          m_tuser;

    entry_t          history [MaxEntries];
    int unsigned     history_total = 0;
    logic [CapW-1:0] capacity_reg  = CapReset;

    access_result_t pending_results [$];
    int             mismatches     = 0;
    int             send_idle_pct  = 0;
    int             recv_stall_pct = 0;
    int             hold_request   = 0;
    int             hold_left      = 0;
    logic [31:0]    key_base       = 32'h0;

    lru_history_list u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        #1ms;
        $display("tb_lru_history_list failed");
        $finish;
    end

    function automatic access_result_t apply_access(input logic act, input entry_t e);
        entry_t         merged [MaxEntries + 1];
        access_result_t r;
        int unsigned    n;
        int unsigned    limit;
        int unsigned    i;
        logic           found;
        r     = '0;
        found = 1'b0;
        n     = 1;
        if (act == ActClear)
        begin
            history_total = 0;
            return r;
        end
        if (capacity_reg == 0)
            limit = 1;
        else if (capacity_reg > MaxEntries)
            limit = MaxEntries;
        else
            limit = 32'(capacity_reg);
        merged[0] = e;
        for (i = 0; i < history_total; i++)
        begin
            if (!found && history[i].key == e.key)
                found = 1'b1;
            else
            begin
                merged[n] = history[i];
                n++;
            end
        end
        if (n > limit)
        begin
            n--;
            r.evicted = 1'b1;
            r.victim  = merged[n];
        end
        for (i = 0; i < n; i++)
            history[i] = merged[i];
        history_total = n;
        r.hit = found;
        r.occ = n[OccW-1:0];
        return r;
    endfunction

    function automatic entry_t make_entry(input logic [31:0] key, input logic [9:0] id,
                                          input logic [31:0] stamp, input logic [15:0] acc);
        entry_t e;
        e.key   = key;
        e.id    = id;
        e.stamp = stamp;
        e.acc   = acc;
        return e;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h actual %h at %t", name, want, got, $realtime);
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        access_result_t want;
        entry_t         got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[EntryW-1:0];
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: unexpected result %h at %t", m_tdata, $realtime);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("hit", 32'(want.hit), 32'(m_tuser[0]));
                check_field("evicted", 32'(want.evicted), 32'(m_tuser[1]));
                check_field("evicted_key", want.victim.key, got.key);
                check_field("evicted_id", 32'(want.victim.id), 32'(got.id));
                check_field("evicted_time", want.victim.stamp, got.stamp);
                check_field("evicted_count", 32'(want.victim.acc), 32'(got.acc));
                check_field("occupancy", 32'(want.occ), 32'(m_tdata[EntryW +: OccW]));
            end
        end
    end

    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                m_tready <= 1'b0;
                hold_left--;
            end
            else
                m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    task automatic send_item(input logic act, input entry_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= InDataW'(e);
        do @(posedge clk); while (!s_tready);
        pending_results.push_back(apply_access(act, e));
        @(negedge clk);
    endtask

    task automatic insert(input logic [31:0] key);
        send_item(ActInsert, make_entry(key, 10'($urandom_range(999)), $urandom,
                                        16'($urandom_range(65535))));
    endtask

    task automatic send_random(input int key_span);
        logic [31:0] key;
        if ($urandom_range(99) < 4)
            send_item(ActClear, make_entry($urandom, 10'($urandom_range(999)), $urandom,
                                           16'($urandom_range(65535))));
        else
        begin
            if ($urandom_range(99) < 70)
                key = key_base + $urandom_range(key_span);
            else
                key = $urandom;
            insert(key);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (MaxEntries + 4) @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CapW-1:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        capacity_reg = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_idle(input int send_pct, input int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        set_idle(0, 0);
        send_item(ActInsert, make_entry(32'h0, 10'd0, 32'h0, 16'h0));
        send_item(ActInsert, make_entry(32'hFFFF_FFFF, 10'd999, 32'hFFFF_FFFF, 16'hFFFF));
        send_item(ActInsert, make_entry(32'h0, 10'd512, 32'h8000_0000, 16'h8000));
        for (int k = 100; k < 110; k++)
            insert(k);
        insert(105);
        send_item(ActClear, make_entry($urandom, 10'd999, $urandom, 16'hFFFF));
        send_item(ActClear, make_entry(32'h0, 10'd0, 32'h0, 16'h0));
        insert(32'h1234_5678);
    endtask

    task automatic test_capacity_limits();
        set_idle(19, 19);
        write_capacity(CapW'(0));
        insert(1);
        insert(2);
        insert(2);
        insert(3);
        write_capacity(CapW'(31));
        for (int k = 0; k < 20; k++)
            insert(32'h100 + k);
        insert(32'h104);
        write_capacity(CapW'(1));
        insert(7);
        insert(8);
        write_capacity(CapW'(16));
        for (int k = 0; k < 18; k++)
            insert(32'h200 + k);
    endtask

    task automatic test_capacity_shrink();
        set_idle(0, 71);
        write_capacity(CapW'(16));
        for (int k = 0; k < 16; k++)
            insert(32'h300 + k);
        write_capacity(CapW'(3));
        for (int k = 0; k < 16; k++)
            insert(32'h300 + ((k * 5) % 16));
        insert(32'h400);
    endtask

    task automatic test_random_traffic();
        logic [CapW-1:0] caps [4];
        int              send_pct [4];
        int              recv_pct [4];
        caps     = '{CapW'(10), CapW'(16), CapW'(3), CapW'($urandom_range(31))};
        send_pct = '{0, 71, 0, 19};
        recv_pct = '{0, 0, 71, 19};
        for (int m = 0; m < 4; m++)
        begin
            write_capacity(caps[m]);
            set_idle(send_pct[m], recv_pct[m]);
            key_base = $urandom;
            repeat (70) send_random(20);
        end
    endtask

    task automatic test_backpressure();
        write_capacity(CapW'(12));
        set_idle(0, 0);
        key_base     = $urandom;
        hold_request = 400;
        repeat (40) send_random(16);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_capacity_limits();
        test_capacity_shrink();
        test_random_traffic();
        test_backpressure();
        drain();
        if (mismatches == 0)
            $display("tb_lru_history_list passed");
        else
            $display("tb_lru_history_list failed");
        $finish;
    end

endmodule
